FILE: rtl/core/rv32i_instruction_step_assert.svh
// Assertion macros for the core RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef RV32I_INSTRUCTION_STEP_ASSERT_SVH
`define RV32I_INSTRUCTION_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rvs assertion failed");

// Next-cycle implication, checked outside reset.
`define RVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rvs assertion failed");

`endif

FILE: rtl/core/rvs_pkg.sv
// Shared types, codes and the ALU function of the RV32I step core.
// No dependencies.
package rvs_pkg;

    localparam int unsigned MEM_BYTES_DEF = 4096;
    localparam int unsigned Q_DEPTH       = 2;

    typedef enum logic [1:0] {
        OP_WRITE_MEM = 2'd0,
        OP_STEP      = 2'd1,
        OP_READ_REG  = 2'd2,
        OP_SET_PC    = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [11:0] address;
        logic [31:0] data;
    } t_item;

    typedef enum logic [2:0] {
        TRAP_NONE       = 3'd0,
        TRAP_ILLEGAL    = 3'd1,
        TRAP_MISALIGNED = 3'd2,
        TRAP_ECALL      = 3'd3,
        TRAP_EBREAK     = 3'd4
    } t_trap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_FETCH,
        ST_EXEC,
        ST_LOAD
    } t_state;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
    localparam logic [6:0]  F7_ALT     = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        case (f3)
            F3_ADD:  r = alt ? (a - b) : (a + b);
            F3_SLL:  r = a << b[4:0];
            F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: r = {31'd0, a < b};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/rvs_front.sv
// Front end: accepts request transactions, classifies the mode and queues them.
// Depends on rvs_pkg.
module rvs_front
    import rvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_address,
    input  logic [31:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    localparam int unsigned PW = $clog2(Q_DEPTH);

    t_item            r_q [Q_DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_cnt;
    t_item            w_item;
    logic             w_push, w_pop;

    always_comb begin
        w_item.address = i_address;
        w_item.data    = i_data;
        unique case (i_mode)
            2'd0:    w_item.op = OP_WRITE_MEM;
            2'd1:    w_item.op = OP_STEP;
            2'd2:    w_item.op = OP_READ_REG;
            default: w_item.op = OP_SET_PC;
        endcase
    end

    assign o_ready = (r_cnt != (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rptr];
    assign w_push  = i_valid & o_ready;
    assign w_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

endmodule

FILE: rtl/core/rvs_mem.sv
// Byte-addressed local memory in four byte lanes, any alignment, little endian.
// Depends on rvs_pkg; MEM_BYTES must be a power of two.
module rvs_mem
    import rvs_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_re,
    input  logic [$clog2(MEM_BYTES)-1:0] i_raddr,
    output logic [31:0]                  o_rdata,
    input  logic                         i_we,
    input  logic [$clog2(MEM_BYTES)-1:0] i_waddr,
    input  logic [31:0]                  i_wdata,
    input  logic [3:0]                   i_wmask
);

    localparam int unsigned AW   = $clog2(MEM_BYTES);
    localparam int unsigned ROWS = MEM_BYTES / 4;

    logic [7:0] r_rbyte [4];
    logic [1:0] r_off;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_off <= i_raddr[1:0];
        end
    end

    for (genvar L = 0; L < 4; L++) begin : g_lane
        logic [7:0]    r_mem [ROWS];
        logic [1:0]    w_kw, w_kr;
        logic [AW-1:0] w_aw, w_ar;

        // byte k of the word lands in lane (addr + k) mod 4
        assign w_kw = 2'(L) - i_waddr[1:0];
        assign w_kr = 2'(L) - i_raddr[1:0];
        assign w_aw = i_waddr + AW'(w_kw);
        assign w_ar = i_raddr + AW'(w_kr);

        always_ff @(posedge i_clk) begin
            if (i_we && i_wmask[w_kw]) begin
                r_mem[w_aw[AW-1:2]] <= i_wdata[8*w_kw +: 8];
            end
            if (i_re) begin
                r_rbyte[L] <= r_mem[w_ar[AW-1:2]];
            end
        end

        assign o_rdata[8*L +: 8] = r_rbyte[2'(r_off + 2'(L))];
    end

endmodule

FILE: rtl/core/rvs_regfile.sv
// 32 x 32 register file, two registered read ports, one write port.
// Depends on rvs_pkg; valid bits make unwritten entries read as zero.
module rvs_regfile
    import rvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_ra1,
    input  logic [4:0]  i_ra2,
    output logic [31:0] o_rd1,
    output logic [31:0] o_rd2,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_d1, r_d2;
    logic        r_v1, r_v2;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_d1 <= r_mem[i_ra1];
            r_d2 <= r_mem[i_ra2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wa] <= 1'b1;
            end
            if (i_re) begin
                r_v1 <= r_vld[i_ra1];
                r_v2 <= r_vld[i_ra2];
            end
        end
    end

    assign o_rd1 = r_v1 ? r_d1 : '0;
    assign o_rd2 = r_v2 ? r_d2 : '0;

endmodule

FILE: rtl/core/rvs_back.sv
// Back end: sequencer that carries out queued requests and executes RV32I instructions.
// Depends on rvs_pkg, rvs_mem, rvs_regfile and the assertion macro header.
`include "rv32i_instruction_step_assert.svh"
module rvs_back
    import rvs_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic [31:0] o_pc_now,
    output logic [2:0]  o_trap_code
);

    localparam int unsigned AW = $clog2(MEM_BYTES);

    t_state      r_state, n_state;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_ins;
    logic        r_out_valid;
    logic [31:0] r_out_rdata, r_out_pc;
    t_trap       r_out_trap;

    logic        w_done;
    logic [31:0] w_done_rdata;
    t_trap       w_done_trap;
    logic        w_out_free, w_pop, w_ins_ld;

    logic          w_mre, w_mwe;
    logic [AW-1:0] w_mra, w_mwa;
    logic [31:0]   w_mrd, w_mwd;
    logic [3:0]    w_mmask;

    logic        w_rre, w_rwe;
    logic [4:0]  w_ra1, w_ra2, w_rwa;
    logic [31:0] w_rd1, w_rd2, w_rwd;

    rvs_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_re    (w_mre),
        .i_raddr (w_mra),
        .o_rdata (w_mrd),
        .i_we    (w_mwe),
        .i_waddr (w_mwa),
        .i_wdata (w_mwd),
        .i_wmask (w_mmask)
    );

    rvs_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_rre),
        .i_ra1   (w_ra1),
        .i_ra2   (w_ra2),
        .o_rd1   (w_rd1),
        .o_rd2   (w_rd2),
        .i_we    (w_rwe),
        .i_wa    (w_rwa),
        .i_wd    (w_rwd)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_pop      = i_valid && o_ready;

    always_comb begin
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [31:0] pc4, jalr_t, jal_t, br_t, lval;
        logic        take;
        t_trap       trap;
        logic        wr;
        logic [31:0] wval, nxt;

        opc   = r_ins[6:0];
        f3    = r_ins[14:12];
        f7    = r_ins[31:25];
        rd    = r_ins[11:7];
        imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
        imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
        imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
        imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
        imm_u = {r_ins[31:12], 12'd0};
        pc4    = r_pc + 32'd4;
        jalr_t = (w_rd1 + imm_i) & ~32'd1;
        jal_t  = r_pc + imm_j;
        br_t   = r_pc + imm_b;
        trap   = TRAP_NONE;
        wr     = 1'b0;
        wval   = '0;
        nxt    = pc4;
        lval   = '0;

        n_state      = r_state;
        n_pc         = r_pc;
        w_done       = 1'b0;
        w_done_rdata = '0;
        w_done_trap  = TRAP_NONE;
        w_ins_ld     = 1'b0;
        w_mre        = 1'b0;
        w_mra        = r_pc[AW-1:0];
        w_mwe        = 1'b0;
        w_mwa        = AW'(i_item.address);
        w_mwd        = i_item.data;
        w_mmask      = 4'b1111;
        w_rre        = 1'b0;
        w_ra1        = i_item.address[4:0];
        w_ra2        = w_mrd[24:20];
        w_rwe        = 1'b0;
        w_rwa        = rd;
        w_rwd        = '0;

        case (f3)
            3'd0:    take = (w_rd1 == w_rd2);
            3'd1:    take = (w_rd1 != w_rd2);
            3'd4:    take = $signed(w_rd1) < $signed(w_rd2);
            3'd5:    take = !($signed(w_rd1) < $signed(w_rd2));
            3'd6:    take = (w_rd1 < w_rd2);
            default: take = (w_rd1 >= w_rd2);
        endcase

        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    unique case (i_item.op)
                        OP_WRITE_MEM: begin
                            w_mwe  = 1'b1;
                            w_done = 1'b1;
                        end
                        OP_SET_PC: begin
                            n_pc   = i_item.data;
                            w_done = 1'b1;
                        end
                        OP_READ_REG: begin
                            w_rre   = 1'b1;
                            n_state = ST_REG;
                        end
                        default: begin
                            w_mre   = 1'b1;
                            n_state = ST_FETCH;
                        end
                    endcase
                end
            end
            ST_REG: begin
                w_done_rdata = w_rd1;
                w_done       = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_FETCH: begin
                // latch the word and read both source registers from it
                w_ins_ld = 1'b1;
                w_rre    = 1'b1;
                w_ra1    = w_mrd[19:15];
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (opc)
                    OPC_LUI: begin
                        wr = 1'b1; wval = imm_u;
                    end
                    OPC_AUIPC: begin
                        wr = 1'b1; wval = r_pc + imm_u;
                    end
                    OPC_JAL: begin
                        if (jal_t[1:0] != 2'd0) begin
                            trap = TRAP_MISALIGNED;
                        end else begin
                            wr = 1'b1; wval = pc4; nxt = jal_t;
                        end
                    end
                    OPC_JALR: begin
                        if (f3 != 3'd0) begin
                            trap = TRAP_ILLEGAL;
                        end else if (jalr_t[1]) begin
                            trap = TRAP_MISALIGNED;
                        end else begin
                            wr = 1'b1; wval = pc4; nxt = jalr_t;
                        end
                    end
                    OPC_BRANCH: begin
                        if (f3 == 3'd2 || f3 == 3'd3) begin
                            trap = TRAP_ILLEGAL;
                        end else if (take) begin
                            if (br_t[1:0] != 2'd0) begin
                                trap = TRAP_MISALIGNED;
                            end else begin
                                nxt = br_t;
                            end
                        end
                    end
                    OPC_LOAD: begin
                        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
                            trap = TRAP_ILLEGAL;
                        end
                    end
                    OPC_STORE: begin
                        if (f3 > 3'd2) begin
                            trap = TRAP_ILLEGAL;
                        end
                    end
                    OPC_OPIMM: begin
                        if (f3 == F3_SLL && f7 != 7'd0) begin
                            trap = TRAP_ILLEGAL;
                        end else if (f3 == F3_SR && f7 != 7'd0 && f7 != F7_ALT) begin
                            trap = TRAP_ILLEGAL;
                        end else begin
                            wr   = 1'b1;
                            wval = alu(f3, (f3 == F3_SR) && r_ins[30], w_rd1, imm_i);
                        end
                    end
                    OPC_OP: begin
                        if (f7 == F7_ALT && f3 != F3_ADD && f3 != F3_SR) begin
                            trap = TRAP_ILLEGAL;
                        end else if (f7 != F7_ALT && f7 != 7'd0) begin
                            trap = TRAP_ILLEGAL;
                        end else begin
                            wr = 1'b1; wval = alu(f3, r_ins[30], w_rd1, w_rd2);
                        end
                    end
                    OPC_SYSTEM: begin
                        if (r_ins == INS_ECALL) begin
                            trap = TRAP_ECALL;
                        end else if (r_ins == INS_EBREAK) begin
                            trap = TRAP_EBREAK;
                        end else begin
                            trap = TRAP_ILLEGAL;
                        end
                    end
                    default: trap = TRAP_ILLEGAL;
                endcase

                if (trap == TRAP_NONE && opc == OPC_LOAD) begin
                    // issue the data read and finish in the load state
                    w_mre   = 1'b1;
                    w_mra   = AW'(w_rd1 + imm_i);
                    n_state = ST_LOAD;
                end else begin
                    if (trap == TRAP_NONE) begin
                        n_pc  = nxt;
                        w_rwe = wr && (rd != 5'd0);
                        w_rwd = wval;
                        if (opc == OPC_STORE) begin
                            w_mwe = 1'b1;
                            w_mwa = AW'(w_rd1 + imm_s);
                            w_mwd = w_rd2;
                            case (f3)
                                3'd0:    w_mmask = 4'b0001;
                                3'd1:    w_mmask = 4'b0011;
                                default: w_mmask = 4'b1111;
                            endcase
                        end
                    end
                    w_done_trap = trap;
                    w_done      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_LOAD: begin
                case (f3)
                    3'd0:    lval = {{24{w_mrd[7]}}, w_mrd[7:0]};
                    3'd1:    lval = {{16{w_mrd[15]}}, w_mrd[15:0]};
                    3'd4:    lval = {24'd0, w_mrd[7:0]};
                    3'd5:    lval = {16'd0, w_mrd[15:0]};
                    default: lval = w_mrd;
                endcase
                w_rwe   = (rd != 5'd0);
                w_rwd   = lval;
                n_pc    = pc4;
                w_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_ld) begin
            r_ins <= w_mrd;
        end
        if (w_done) begin
            r_out_rdata <= w_done_rdata;
            r_out_pc    <= n_pc;
            r_out_trap  <= w_done_trap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_pc_now    = r_out_pc;
    assign o_trap_code = r_out_trap;

    `RVS_ASSERT_NOW(a_x0_kept, w_rwe, w_rwa != 5'd0)
    `RVS_ASSERT_NOW(a_busy_out_empty, r_state != ST_IDLE, !r_out_valid)
    `RVS_ASSERT_NEXT(a_trap_pc_held, w_done && w_done_trap != TRAP_NONE, $stable(r_pc))
    `RVS_ASSERT_NOW(a_pop_idle, w_pop, r_state == ST_IDLE)

endmodule

FILE: rtl/core/rv32i_instruction_step.sv
// RV32I step core: every request transaction (write a memory word, execute one
// instruction, read a register, set the pc) returns exactly one result transaction
// in order. A two-entry request queue decouples the input from the sequencer, and
// the result register holds each result, and a request enters the sequencer only
// while it is empty or being read. Write memory and set pc finish in the idle state,
// read register passes the register state, an instruction fetch, register read and
// execute, a load also the load state; memory and register file read synchronously.
// Memory holds MEM_BYTES bytes (a power of two), wraps addresses and allows any
// alignment; reading a byte never written returns an unspecified value. On a trap
// nothing changes and the pc stays on the faulting instruction.
// Depends on rvs_pkg, rvs_front and rvs_back.
module rv32i_instruction_step
    import rvs_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic [47:0] s_tdata,   // [11:0] address, [43:12] data, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] read_data, [63:32] pc_now, [66:64] trap_code
);

    logic        w_q_valid, w_q_ready;
    t_item       w_q_item;
    logic [31:0] w_read_data, w_pc_now;
    logic [2:0]  w_trap_code;

    // queue incoming transactions; the mode is classified here
    rvs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_mode    (s_tuser),
        .i_address (s_tdata[11:0]),
        .i_data    (s_tdata[43:12]),
        .o_valid   (w_q_valid),
        .i_ready   (w_q_ready),
        .o_item    (w_q_item)
    );

    // execute one queued transaction at a time and hold its result
    rvs_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_item      (w_q_item),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_read_data (w_read_data),
        .o_pc_now    (w_pc_now),
        .o_trap_code (w_trap_code)
    );

    assign m_tdata = {5'd0, w_trap_code, w_pc_now, w_read_data};

endmodule
